FILE: rtl/core/rsp_pkg.sv
// ---------------------------------------------------------------------------
// rsp_pkg
// shared constants, types and helpers of the receiver status parser
// ---------------------------------------------------------------------------
package rsp_pkg;

	localparam int LINE_MAX_DEF = 64;

	localparam logic [1:0] OP_BYTE = 2'd0;
	localparam logic [1:0] OP_REQ  = 2'd1;
	localparam logic [1:0] OP_TICK = 2'd2;

	localparam logic CFG_OWN_MAX      = 1'b0;
	localparam logic CFG_MIN_INTERVAL = 1'b1;

	localparam logic signed [7:0] OWN_MAX_RST  = 8'sd18;
	localparam logic [15:0]       MIN_INT_RST  = 16'd100;
	localparam logic [7:0]        CEIL_LIMIT   = 8'd196;
	localparam logic [15:0]       SINCE_SAT    = 16'hFFFF;

	localparam logic [2:0] MSG_NONE  = 3'd0;
	localparam logic [2:0] MSG_MAX   = 3'd1;
	localparam logic [2:0] MSG_VOL   = 3'd2;
	localparam logic [2:0] MSG_MUTE  = 3'd3;
	localparam logic [2:0] MSG_POWER = 3'd4;

	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_SP = 8'h20;
	localparam logic [7:0] CH_0  = 8'h30;
	localparam logic [7:0] CH_5  = 8'h35;
	localparam logic [7:0] CH_9  = 8'h39;
	localparam logic [7:0] CH_A  = 8'h41;
	localparam logic [7:0] CH_M  = 8'h4D;
	localparam logic [7:0] CH_N  = 8'h4E;
	localparam logic [7:0] CH_O  = 8'h4F;
	localparam logic [7:0] CH_P  = 8'h50;
	localparam logic [7:0] CH_U  = 8'h55;
	localparam logic [7:0] CH_V  = 8'h56;
	localparam logic [7:0] CH_W  = 8'h57;
	localparam logic [7:0] CH_X  = 8'h58;
	localparam logic [7:0] CH_Z  = 8'h5A;

	typedef struct packed {
		logic [2:0] kind;
		logic [7:0] half;
		logic       on;
	} msg_t;

	typedef struct packed {
		logic [7:0] volume_half;
		logic [7:0] ceiling_half;
		logic       have_volume;
		logic       muted;
		logic       powered;
		logic       changed;
		logic       send;
		logic [7:0] target;
	} res_t;

	function automatic logic is_dig(input logic [7:0] c);
		return (c >= CH_0) && (c <= CH_9);
	endfunction

	function automatic logic is_ws(input logic [7:0] c);
		return (c == CH_SP) || ((c >= 8'd9) && (c <= 8'd13));
	endfunction

	// two ascii digits and a half flag to half steps
	function automatic logic [7:0] half_of(input logic [7:0] d0, input logic [7:0] d1,
		input logic five);
		logic [7:0] v;
		v = 8'({d0[3:0], 3'b000}) + 8'({d0[3:0], 1'b0}) + 8'(d1[3:0]);
		return {v[6:0], five};
	endfunction

	// min of device ceiling and user ceiling, clamped to 0..196
	function automatic logic [7:0] ceil_of(input logic [7:0] dev, input logic signed [7:0] own);
		logic signed [10:0] own2;
		logic signed [10:0] dev_s;
		logic signed [10:0] m;
		own2  = (11'(own) + 11'sd80) <<< 1;
		dev_s = signed'(11'(dev));
		m     = (dev_s < own2) ? dev_s : own2;
		if (m < 11'sd0) begin
			m = 11'sd0;
		end else if (m > signed'(11'(CEIL_LIMIT))) begin
			m = signed'(11'(CEIL_LIMIT));
		end
		return m[7:0];
	endfunction

	// w / 10 for w below 100
	function automatic logic [3:0] tens_of(input logic [6:0] w);
		logic [14:0] p;
		p = 15'(w) * 15'd205;
		return p[14:11];
	endfunction

endpackage

FILE: rtl/core/receiver_status_parser_volume_sender_core.sv
// ---------------------------------------------------------------------------
// receiver_status_parser_volume_sender_core
// receiver status line decoder and rate-limited volume command sender
// ---------------------------------------------------------------------------
// An item moves from the input register to the result register as soon as
// the output stage is free, so items that give one status result stream
// at one per cycle while the output does not stall. A tick that sends a
// volume command gives 5 or 6 results, one per cycle from the command
// sequencer in the output stage unless the output stalls; during that run
// the input register holds one further item and then stalls the input.
// Received lines are decoded on the fly as bytes arrive.
module receiver_status_parser_volume_sender_core
	import rsp_pkg::*;
#(
	parameter int LINE_MAX = LINE_MAX_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        opcode,
	input  logic [7:0]        rx_byte,
	input  logic signed [9:0] volume_request,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic              cfg_index,
	input  logic [15:0]       cfg_data,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [7:0]        volume_half,
	output logic [7:0]        ceiling_half,
	output logic              have_volume,
	output logic              muted,
	output logic              powered,
	output logic              changed,
	output logic              tx_valid,
	output logic [7:0]        tx_byte,
	output logic              last
);

	logic              valid_s1;
	logic [1:0]        op_s1;
	logic [7:0]        rx_s1;
	logic signed [9:0] req_s1;

	logic signed [7:0] own_max_q;
	logic [15:0]       min_int_q;
	logic [7:0]        vol_q;
	logic [7:0]        dev_q;
	logic [7:0]        target_q;
	logic              pend_q;
	logic [15:0]       since_q;
	logic              have_q;
	logic              mute_q;
	logic              power_q;

	logic [7:0]  vol_d;
	logic [7:0]  dev_d;
	logic [7:0]  target_d;
	logic        pend_d;
	logic [15:0] since_d;
	logic        have_d;
	logic        mute_d;
	logic        power_d;
	logic        chg;
	logic        send;
	logic [15:0] since_inc;
	logic [7:0]  ceil_now;
	logic [7:0]  req_clamp;

	logic  accept;
	logic  proc;
	logic  free;
	msg_t  msg;
	res_t  res;

	assign cfg_ready = 1'b1;
	assign in_stall  = valid_s1 && !free;
	assign accept    = in_valid && !in_stall;
	assign proc      = valid_s1 && free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (proc) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1  <= opcode;
			rx_s1  <= rx_byte;
			req_s1 <= volume_request;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_max_q <= OWN_MAX_RST;
			min_int_q <= MIN_INT_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_OWN_MAX:      own_max_q <= signed'(cfg_data[7:0]);
				CFG_MIN_INTERVAL: min_int_q <= cfg_data;
				default:          own_max_q <= own_max_q;
			endcase
		end
	end

	rsp_line_parser #(
		.LINE_MAX(LINE_MAX)
	) u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.byte_en (proc && (op_s1 == OP_BYTE)),
		.rx_byte (rx_s1),
		.msg     (msg)
	);

	assign ceil_now  = ceil_of(dev_q, own_max_q);
	assign since_inc = (since_q == SINCE_SAT) ? since_q : since_q + 16'd1;

	always_comb begin
		if (req_s1[9]) begin
			req_clamp = 8'd0;
		end else if (req_s1[8:0] > 9'(ceil_now)) begin
			req_clamp = ceil_now;
		end else begin
			req_clamp = req_s1[7:0];
		end
	end

	always_comb begin
		vol_d    = vol_q;
		dev_d    = dev_q;
		target_d = target_q;
		pend_d   = pend_q;
		since_d  = since_q;
		have_d   = have_q;
		mute_d   = mute_q;
		power_d  = power_q;
		chg      = 1'b0;
		send     = 1'b0;
		case (op_s1)
			OP_BYTE: begin
				unique case (msg.kind)
					MSG_MAX: begin
						dev_d = msg.half;
						chg   = 1'b1;
					end
					MSG_VOL: begin
						if (!pend_q) begin
							vol_d = msg.half;
						end
						have_d = 1'b1;
						chg    = 1'b1;
					end
					MSG_MUTE: begin
						mute_d = msg.on;
						chg    = 1'b1;
					end
					MSG_POWER: begin
						power_d = msg.on;
						chg     = 1'b1;
					end
					default: chg = 1'b0;
				endcase
			end
			OP_REQ: begin
				target_d = req_clamp;
				vol_d    = req_clamp;
				pend_d   = 1'b1;
				chg      = 1'b1;
			end
			OP_TICK: begin
				since_d = since_inc;
				if (pend_q && (since_inc >= min_int_q)) begin
					send    = 1'b1;
					since_d = '0;
					pend_d  = 1'b0;
				end
			end
			default: chg = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vol_q    <= '0;
			dev_q    <= CEIL_LIMIT;
			target_q <= '0;
			pend_q   <= 1'b0;
			since_q  <= SINCE_SAT;
			have_q   <= 1'b0;
			mute_q   <= 1'b0;
			power_q  <= 1'b0;
		end else if (proc) begin
			vol_q    <= vol_d;
			dev_q    <= dev_d;
			target_q <= target_d;
			pend_q   <= pend_d;
			since_q  <= since_d;
			have_q   <= have_d;
			mute_q   <= mute_d;
			power_q  <= power_d;
		end
	end

	always_comb begin
		res.volume_half  = vol_d;
		res.ceiling_half = ceil_of(dev_d, own_max_q);
		res.have_volume  = have_d;
		res.muted        = mute_d;
		res.powered      = power_d;
		res.changed      = chg;
		res.send         = send;
		res.target       = target_q;
	end

	rsp_out_seq u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (proc),
		.res          (res),
		.free         (free),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.volume_half  (volume_half),
		.ceiling_half (ceiling_half),
		.have_volume  (have_volume),
		.muted        (muted),
		.powered      (powered),
		.changed      (changed),
		.tx_valid     (tx_valid),
		.tx_byte      (tx_byte),
		.last         (last)
	);

	// a command run is not cut short
	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && tx_valid && !last |=> out_valid && tx_valid)
		else $error("command run broken");

	// a status result is always the only result of its item
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !tx_valid |-> last)
		else $error("status result not last");

	// sending clears the pending target and restarts the interval
	a_send_clears: assert property (@(posedge clk) disable iff (!arst_n)
		proc && send |=> !pend_q && (since_q == 16'd0))
		else $error("send did not clear pending state");

	// command bytes never flag a status change
	a_cmd_no_change: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && tx_valid |-> !changed)
		else $error("command result flagged as change");

endmodule

FILE: rtl/core/rsp_line_parser.sv
// ---------------------------------------------------------------------------
// rsp_line_parser
// assembles received bytes into lines and decodes each line as it ends
// ---------------------------------------------------------------------------
module rsp_line_parser
	import rsp_pkg::*;
#(
	parameter int LINE_MAX = LINE_MAX_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       byte_en,
	input  logic [7:0] rx_byte,
	output msg_t       msg
);

	localparam int LW = $clog2(LINE_MAX + 1);

	logic [LW-1:0] len_q;
	logic [7:0]    head_q [5];
	logic [7:0]    prev1_q;
	logic [7:0]    prev2_q;
	logic [1:0]    mx_cnt_q;
	logic [7:0]    mx_q [3];

	logic term;
	logic store;
	logic max_line;
	logic mv_line;
	logic [7:0] mx_half;
	logic [7:0] mv_half;

	assign term  = (rx_byte == CH_CR) || (rx_byte == CH_LF);
	assign store = byte_en && !term && (len_q < LW'(LINE_MAX));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q    <= '0;
			mx_cnt_q <= '0;
		end else if (byte_en && term) begin
			len_q    <= '0;
			mx_cnt_q <= '0;
		end else if (store) begin
			len_q <= len_q + LW'(1);
			if ((len_q >= LW'(5)) && !((mx_cnt_q == 2'd0) && is_ws(rx_byte)) &&
				(mx_cnt_q != 2'd3)) begin
				mx_cnt_q <= mx_cnt_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (store) begin
			prev1_q <= rx_byte;
			prev2_q <= prev1_q;
			if (len_q < LW'(5)) begin
				head_q[len_q[2:0]] <= rx_byte;
			end else if (!((mx_cnt_q == 2'd0) && is_ws(rx_byte)) && (mx_cnt_q != 2'd3)) begin
				mx_q[mx_cnt_q] <= rx_byte;
			end
		end
	end

	assign max_line = (len_q >= LW'(5)) && (head_q[0] == CH_M) && (head_q[1] == CH_V) &&
		(head_q[2] == CH_M) && (head_q[3] == CH_A) && (head_q[4] == CH_X);
	assign mv_line  = (head_q[0] == CH_M) && (head_q[1] == CH_V);
	assign mx_half  = half_of(mx_q[0], mx_q[1], (mx_cnt_q == 2'd3) && (mx_q[2] == CH_5));
	assign mv_half  = half_of(head_q[2], head_q[3], (len_q >= LW'(5)) && (head_q[4] == CH_5));

	always_comb begin
		msg.kind = MSG_NONE;
		msg.half = '0;
		msg.on   = (prev2_q == CH_O) && (prev1_q == CH_N);
		if (byte_en && term && (len_q >= LW'(2))) begin
			if (max_line) begin
				msg.half = mx_half;
				if ((mx_cnt_q >= 2'd2) && is_dig(mx_q[0]) && is_dig(mx_q[1]) &&
					(mx_half != 8'd0) && (mx_half <= CEIL_LIMIT)) begin
					msg.kind = MSG_MAX;
				end
			end else if (mv_line) begin
				msg.half = mv_half;
				if ((len_q >= LW'(4)) && is_dig(head_q[2]) && is_dig(head_q[3])) begin
					msg.kind = MSG_VOL;
				end
			end else if ((head_q[0] == CH_M) && (head_q[1] == CH_U)) begin
				msg.kind = MSG_MUTE;
			end else if (((head_q[0] == CH_Z) && (head_q[1] == CH_M)) ||
				((head_q[0] == CH_P) && (head_q[1] == CH_W))) begin
				msg.kind = MSG_POWER;
			end
		end
	end

endmodule

FILE: rtl/core/rsp_out_seq.sv
// ---------------------------------------------------------------------------
// rsp_out_seq
// result register and command byte sequencer
// ---------------------------------------------------------------------------
module rsp_out_seq
	import rsp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       load,
	input  res_t       res,
	output logic       free,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] volume_half,
	output logic [7:0] ceiling_half,
	output logic       have_volume,
	output logic       muted,
	output logic       powered,
	output logic       changed,
	output logic       tx_valid,
	output logic [7:0] tx_byte,
	output logic       last
);

	res_t       res_q;
	logic       valid_q;
	logic [2:0] idx_q;
	logic [3:0] tens_q;
	logic [3:0] ones_q;
	logic [3:0] tens;
	logic       take;
	logic [7:0] cmd_byte;

	assign tens = tens_of(res.target[7:1]);
	assign last = !res_q.send || (idx_q == (res_q.target[0] ? 3'd5 : 3'd4));
	assign take = valid_q && !out_stall;
	assign free = !valid_q || (take && last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (load) begin
			valid_q <= 1'b1;
			idx_q   <= '0;
		end else if (take) begin
			if (last) begin
				valid_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q  <= res;
			tens_q <= tens;
			ones_q <= 4'(res.target[7:1] - 7'(tens) * 7'd10);
		end
	end

	always_comb begin
		unique case (idx_q)
			3'd0:    cmd_byte = CH_M;
			3'd1:    cmd_byte = CH_V;
			3'd2:    cmd_byte = CH_0 + 8'(tens_q);
			3'd3:    cmd_byte = CH_0 + 8'(ones_q);
			3'd4:    cmd_byte = res_q.target[0] ? CH_5 : CH_CR;
			default: cmd_byte = CH_CR;
		endcase
	end

	assign out_valid    = valid_q;
	assign volume_half  = res_q.volume_half;
	assign ceiling_half = res_q.ceiling_half;
	assign have_volume  = res_q.have_volume;
	assign muted        = res_q.muted;
	assign powered      = res_q.powered;
	assign changed      = res_q.changed;
	assign tx_valid     = res_q.send;
	assign tx_byte      = res_q.send ? cmd_byte : 8'd0;

endmodule

FILE: bench/status_score_pkg.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// status_score_pkg
// shadow copy of the receiver status parser that tracks line, volume and
// power state, predicts the status and command items of every accepted
// input item and matches them in order against what the core puts out
// ---------------------------------------------------------------------------
package status_score_pkg;
	import rsp_pkg::*;

	localparam int SHADOW_LINE_MAX = LINE_MAX_DEF;
	localparam int DB_OFFSET       = 80;
	localparam int REPORT_LIMIT    = 10;

	typedef struct packed {
		logic [7:0] volume_half;
		logic [7:0] ceiling_half;
		logic       have_volume;
		logic       muted;
		logic       powered;
		logic       changed;
		logic       tx_valid;
		logic [7:0] tx_byte;
		logic       last;
	} status_rec_t;

	class receiver_shadow;
		logic [7:0]        line_buf [SHADOW_LINE_MAX];
		int                line_len;
		logic [7:0]        cur_vol;
		logic [7:0]        dev_ceil;
		logic [7:0]        tgt;
		logic              tgt_valid;
		logic [15:0]       since_ms;
		logic              have_vol;
		logic              mute_on;
		logic              power_on;
		logic signed [7:0] own_max;
		logic [15:0]       min_gap_ms;
		status_rec_t       due_status [$];
		int                bad_count;
		int                shown_count;

		function new();
			foreach (line_buf[i]) begin
				line_buf[i] = 8'd0;
			end
			line_len    = 0;
			cur_vol     = 8'd0;
			dev_ceil    = CEIL_LIMIT;
			tgt         = 8'd0;
			tgt_valid   = 1'b0;
			since_ms    = SINCE_SAT;
			have_vol    = 1'b0;
			mute_on     = 1'b0;
			power_on    = 1'b0;
			own_max     = OWN_MAX_RST;
			min_gap_ms  = MIN_INT_RST;
			bad_count   = 0;
			shown_count = 0;
		endfunction

		function void set_reg(logic idx, logic [15:0] data);
			if (idx == CFG_OWN_MAX) begin
				own_max = data[7:0];
			end else begin
				min_gap_ms = data;
			end
		endfunction

		function int ceiling();
			int own2;
			int m;
			own2 = (int'(own_max) + DB_OFFSET) * 2;
			m = (int'(dev_ceil) < own2) ? int'(dev_ceil) : own2;
			if (m < 0) begin
				m = 0;
			end
			if (m > int'(CEIL_LIMIT)) begin
				m = int'(CEIL_LIMIT);
			end
			return m;
		endfunction

		function bit is_digit(logic [7:0] c);
			return (c >= CH_0) && (c <= CH_9);
		endfunction

		function bit is_space(logic [7:0] c);
			return (c == CH_SP) || ((c >= 8'h09) && (c <= CH_CR));
		endfunction

		function bit starts_with(string p);
			int i;
			if (line_len < p.len()) begin
				return 1'b0;
			end
			for (i = 0; i < p.len(); i++) begin
				if (line_buf[i] != p[i]) begin
					return 1'b0;
				end
			end
			return 1'b1;
		endfunction

		function bit ends_on();
			return (line_len >= 2) && (line_buf[line_len - 2] == CH_O) &&
				(line_buf[line_len - 1] == CH_N);
		endfunction

		// dd with an optional trailing 5, in half steps, or -1
		function int half_at(int p);
			int h;
			if (line_len < p + 2) begin
				return -1;
			end
			if (!is_digit(line_buf[p]) || !is_digit(line_buf[p + 1])) begin
				return -1;
			end
			h = ((int'(line_buf[p]) - int'(CH_0)) * 10 +
				(int'(line_buf[p + 1]) - int'(CH_0))) * 2;
			if ((line_len > p + 2) && (line_buf[p + 2] == CH_5)) begin
				h++;
			end
			return h;
		endfunction

		function bit decode_line();
			int h;
			int p;
			if (line_len < 2) begin
				return 1'b0;
			end
			if (starts_with("MVMAX")) begin
				p = 5;
				while ((p < line_len) && is_space(line_buf[p])) begin
					p++;
				end
				h = half_at(p);
				if ((h > 0) && (h <= int'(CEIL_LIMIT))) begin
					dev_ceil = 8'(h);
					return 1'b1;
				end
				return 1'b0;
			end
			if (starts_with("MV")) begin
				h = half_at(2);
				if (h < 0) begin
					return 1'b0;
				end
				// a pending local target wins over the reported volume
				if (!tgt_valid) begin
					cur_vol = 8'(h);
				end
				have_vol = 1'b1;
				return 1'b1;
			end
			if (starts_with("MU")) begin
				mute_on = ends_on();
				return 1'b1;
			end
			if (starts_with("ZM") || starts_with("PW")) begin
				power_on = ends_on();
				return 1'b1;
			end
			return 1'b0;
		endfunction

		function void add_rec(bit chg, bit txv, logic [7:0] txb, bit fin);
			status_rec_t r;
			r.volume_half  = cur_vol;
			r.ceiling_half = 8'(ceiling());
			r.have_volume  = have_vol;
			r.muted        = mute_on;
			r.powered      = power_on;
			r.changed      = chg;
			r.tx_valid     = txv;
			r.tx_byte      = txv ? txb : 8'd0;
			r.last         = fin;
			due_status.push_back(r);
		endfunction

		function void take_item(logic [1:0] op, logic [7:0] rx, logic signed [9:0] req);
			bit         chg;
			int         r;
			int         whole;
			logic [7:0] cmd [$];
			chg = 1'b0;
			case (op)
				OP_BYTE: begin
					if ((rx == CH_CR) || (rx == CH_LF)) begin
						if (line_len > 0) begin
							chg = decode_line();
						end
						line_len = 0;
					end else if (line_len < SHADOW_LINE_MAX) begin
						line_buf[line_len] = rx;
						line_len++;
					end
				end
				OP_REQ: begin
					r = int'(req);
					if (r < 0) begin
						r = 0;
					end
					if (r > ceiling()) begin
						r = ceiling();
					end
					tgt       = 8'(r);
					tgt_valid = 1'b1;
					cur_vol   = 8'(r);
					chg       = 1'b1;
				end
				OP_TICK: begin
					if (since_ms != SINCE_SAT) begin
						since_ms++;
					end
					if (tgt_valid && (since_ms >= min_gap_ms)) begin
						whole = int'(tgt) / 2;
						cmd.push_back(CH_M);
						cmd.push_back(CH_V);
						cmd.push_back(8'(int'(CH_0) + (whole / 10) % 10));
						cmd.push_back(8'(int'(CH_0) + whole % 10));
						if (tgt[0]) begin
							cmd.push_back(CH_5);
						end
						cmd.push_back(CH_CR);
						since_ms  = 16'd0;
						tgt_valid = 1'b0;
						foreach (cmd[k]) begin
							add_rec(1'b0, 1'b1, cmd[k], k == cmd.size() - 1);
						end
						return;
					end
				end
				default: begin
				end
			endcase
			add_rec(chg, 1'b0, 8'd0, 1'b1);
		endfunction

		function string show(status_rec_t s);
			return $sformatf("vol %0d ceil %0d have %0b mute %0b pwr %0b chg %0b txv %0b tx %02h last %0b",
				s.volume_half, s.ceiling_half, s.have_volume, s.muted, s.powered,
				s.changed, s.tx_valid, s.tx_byte, s.last);
		endfunction

		function void match_status(status_rec_t got);
			status_rec_t want;
			if (due_status.size() == 0) begin
				bad_count++;
				if (shown_count < REPORT_LIMIT) begin
					shown_count++;
					$display("unexpected item: %s", show(got));
				end
				return;
			end
			want = due_status.pop_front();
			if (got !== want) begin
				bad_count++;
				if (shown_count < REPORT_LIMIT) begin
					shown_count++;
					$display("mismatch expected: %s", show(want));
					$display("         actual:   %s", show(got));
				end
			end
		endfunction
	endclass

endpackage

FILE: bench/tb_receiver_status_parser_volume_sender_core.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_receiver_status_parser_volume_sender_core
// drives status lines, volume requests and ticks into the core under a
// series of ceiling and send interval settings, with bursty input, an
// irregular output stall and one long output hold-off, and checks every
// output item against a shadow model of the parser and command sender
// ---------------------------------------------------------------------------
module tb_receiver_status_parser_volume_sender_core;
	import rsp_pkg::*;
	import status_score_pkg::*;

	localparam logic [1:0] OP_SPARE     = 2'd3;
	localparam int         HOLD_CYCLES  = 150;

	typedef enum int {PACE_FREE, PACE_LIGHT, PACE_HALF, PACE_COMB, PACE_HEAVY} pace_t;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	logic [1:0]        opcode;
	logic [7:0]        rx_byte;
	logic signed [9:0] volume_request;
	logic              cfg_valid;
	logic              cfg_ready;
	logic              cfg_index;
	logic [15:0]       cfg_data;
	logic              out_valid;
	logic              out_stall;
	logic [7:0]        volume_half;
	logic [7:0]        ceiling_half;
	logic              have_volume;
	logic              muted;
	logic              powered;
	logic              changed;
	logic              tx_valid;
	logic [7:0]        tx_byte;
	logic              last;

	receiver_shadow shadow = new();
	int             item_count = 0;
	int             burst_left = 0;
	bit             no_gaps = 1'b0;
	bit             hold_req = 1'b0;

	receiver_status_parser_volume_sender_core dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.opcode         (opcode),
		.rx_byte        (rx_byte),
		.volume_request (volume_request),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.volume_half    (volume_half),
		.ceiling_half   (ceiling_half),
		.have_volume    (have_volume),
		.muted          (muted),
		.powered        (powered),
		.changed        (changed),
		.tx_valid       (tx_valid),
		.tx_byte        (tx_byte),
		.last           (last)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("tb_receiver_status_parser_volume_sender_core: FAIL");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			shadow.match_status({volume_half, ceiling_half, have_volume, muted, powered,
				changed, tx_valid, tx_byte, last});
		end
	end

	initial begin : receiver_pace
		int    hold_left;
		int    mode_left;
		int    cyc;
		pace_t mode;
		hold_left = 0;
		mode_left = 0;
		cyc = 0;
		mode = PACE_FREE;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (mode_left == 0) begin
				mode = pace_t'($urandom_range(0, 4));
				mode_left = $urandom_range(20, 80);
			end
			mode_left--;
			cyc++;
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				case (mode)
					PACE_FREE:  out_stall <= 1'b0;
					PACE_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
					PACE_HALF:  out_stall <= 1'($urandom_range(0, 1));
					PACE_COMB:  out_stall <= ((cyc % 5) < 2);
					default:    out_stall <= ($urandom_range(0, 3) != 0);
				endcase
			end
		end
	end

	task automatic push_item(input logic [1:0] op, input logic [7:0] rx,
		input logic signed [9:0] req);
		int gap;
		if ((burst_left == 0) && !no_gaps) begin
			burst_left = $urandom_range(1, 16);
			gap = $urandom_range(0, 6);
			if (gap > 0) begin
				@(negedge clk);
				in_valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		if (burst_left > 0) begin
			burst_left--;
		end
		@(negedge clk);
		in_valid       <= 1'b1;
		opcode         <= op;
		rx_byte        <= rx;
		volume_request <= req;
		do @(posedge clk); while (in_stall);
		shadow.take_item(op, rx, req);
		if (op != OP_SPARE) begin
			item_count++;
		end
	endtask

	task automatic send_line(input string body, input logic [7:0] term);
		int i;
		for (i = 0; i < body.len(); i++) begin
			push_item(OP_BYTE, body[i], 10'($urandom));
		end
		push_item(OP_BYTE, term, 10'($urandom));
	endtask

	task automatic send_ticks(input int n);
		repeat (n) push_item(OP_TICK, 8'($urandom), 10'($urandom));
	endtask

	task automatic write_reg(input logic idx, input logic [15:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		shadow.set_reg(idx, data);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (shadow.due_status.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic rand_step();
		int         pick;
		int         v;
		string      body;
		string      pad;
		string      five;
		logic [7:0] term;
		pick = $urandom_range(0, 99);
		term = $urandom_range(0, 1) ? CH_CR : CH_LF;
		case ($urandom_range(0, 3))
			0: pad = "";
			1: pad = " ";
			2: pad = "  ";
			default: pad = "\t ";
		endcase
		five = $urandom_range(0, 1) ? "5" : "";
		if (pick < 45) begin
			case ($urandom_range(0, 7))
				0, 1: body = $sformatf("MVMAX%s%02d%s", pad, $urandom_range(0, 99), five);
				2, 3: body = $sformatf("MV%02d%s", $urandom_range(0, 99), five);
				4: body = $urandom_range(0, 1) ? "MUON" : "MUOFF";
				5: begin
					case ($urandom_range(0, 3))
						0: body = "ZMON";
						1: body = "PWON";
						2: body = "ZMOFF";
						default: body = "PWSTANDBY";
					endcase
				end
				6: body = $urandom_range(0, 1) ? "SITUNER" : "MSSTEREO";
				default: body = $urandom_range(0, 1) ? "M" : "MV";
			endcase
			send_line(body, term);
		end else if (pick < 60) begin
			case ($urandom_range(0, 9))
				0: v = -512;
				1: v = 511;
				2, 3, 4, 5, 6: v = $urandom_range(0, 200);
				default: v = int'($urandom_range(0, 1023)) - 512;
			endcase
			push_item(OP_REQ, 8'($urandom), 10'(v));
		end else if (pick < 80) begin
			send_ticks($urandom_range(1, 6));
		end else if (pick < 88) begin
			repeat ($urandom_range(1, 5)) push_item(OP_BYTE, 8'($urandom), 10'($urandom));
		end else if (pick < 95) begin
			case ($urandom_range(0, 4))
				0: body = $sformatf("MVMAX%s%0d", pad, $urandom_range(0, 9));
				1: body = "MVMAX 99";
				2: body = "MVMAX005";
				3: body = $sformatf("MV%0d", $urandom_range(0, 9));
				default: body = "MVA5";
			endcase
			send_line(body, term);
		end else if (pick < 98) begin
			push_item(OP_SPARE, 8'($urandom), 10'($urandom));
		end else begin
			push_item(OP_BYTE, term, 10'($urandom));
		end
	endtask

	task automatic run_random(input int n);
		int start;
		start = item_count;
		while (item_count - start < n) begin
			rand_step();
		end
	endtask

	initial begin : stimulus
		string long_line;
		int    v;
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		opcode         = OP_BYTE;
		rx_byte        = 8'd0;
		volume_request = 10'sd0;
		cfg_valid      = 1'b0;
		cfg_index      = CFG_OWN_MAX;
		cfg_data       = 16'd0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset settings: report, clamp both ways, first send, spare opcode, flags
		send_line("MV50", CH_CR);
		push_item(OP_REQ, 8'hFF, 10'sd511);
		send_ticks(1);
		push_item(OP_REQ, 8'h00, -10'sd512);
		send_ticks(1);
		push_item(OP_SPARE, 8'hA5, 10'sh2AA);
		send_line("MUON", CH_LF);
		send_line("PWON", CH_CR);
		send_line("ZMOFF", CH_CR);
		drain();

		// lowest user ceiling, no send interval
		write_reg(CFG_OWN_MAX, 16'(-80));
		write_reg(CFG_MIN_INTERVAL, 16'd0);
		run_random(5);
		drain();

		// highest user ceiling, longest interval, truncated line
		write_reg(CFG_OWN_MAX, 16'(18));
		write_reg(CFG_MIN_INTERVAL, 16'hFFFF);
		long_line = "MU";
		repeat (64) long_line = {long_line, "x"};
		long_line = {long_line, "ON"};
		send_line(long_line, CH_LF);
		run_random(4);
		drain();

		// mid settings with the output held off while input keeps coming
		v = int'($urandom_range(0, 98)) - 80;
		write_reg(CFG_OWN_MAX, 16'(v));
		write_reg(CFG_MIN_INTERVAL, 16'($urandom_range(1, 6)));
		hold_req = 1'b1;
		no_gaps = 1'b1;
		push_item(OP_REQ, 8'($urandom), 10'sd77);
		send_ticks(8);
		push_item(OP_REQ, 8'($urandom), 10'sd150);
		send_ticks(8);
		no_gaps = 1'b0;
		run_random(5);
		drain();

		v = int'($urandom_range(0, 98)) - 80;
		write_reg(CFG_OWN_MAX, 16'(v));
		write_reg(CFG_MIN_INTERVAL, 16'($urandom_range(0, 3)));
		run_random(5);
		drain();

		repeat (16) @(posedge clk);
		if ((shadow.bad_count == 0) && (shadow.due_status.size() == 0)) begin
			$display("tb_receiver_status_parser_volume_sender_core: PASS");
		end else begin
			$display("tb_receiver_status_parser_volume_sender_core: FAIL");
		end
		$finish;
	end

endmodule

FILE: filelist.f
rtl/core/rsp_pkg.sv
rtl/core/rsp_line_parser.sv
rtl/core/rsp_out_seq.sv
rtl/core/receiver_status_parser_volume_sender_core.sv
bench/status_score_pkg.sv
bench/tb_receiver_status_parser_volume_sender_core.sv
